>>> src/lrn_pkg.sv
`default_nettype none

package lrn_pkg;

    // Fixed sizes of the datapath.
    localparam int TABLE_ENTRIES = 256;
    localparam int TAB_BITS      = 8;
    localparam int TAB_W         = 26;
    localparam int DELAY_DEPTH   = 8;
    localparam int MAX_RUN       = 8;
    localparam int RUN_W         = 4;
    localparam int SQ_W          = 32;
    localparam int D_W           = 17;
    localparam int MUL_W         = 34;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;
    localparam logic [20:0] SAT_MAG = 21'h100000;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_SIZE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_K_BIAS     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BETA       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_IN_ZP      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_ZP     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN       = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_PRECISION  = 3'd7;

    typedef logic [TAB_W-1:0] tab_t [TABLE_ENTRIES+1];

    // Settings the normalization engine needs.
    typedef struct packed {
        logic [23:0]        k_bias;
        logic [31:0]        alpha;
        logic [15:0]        beta;
        logic signed [15:0] out_zp;
        logic [31:0]        gain;
        logic               precision;
    } lrn_cfg_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_CHECK,
        T_SUM,
        T_START,
        T_WAIT,
        T_OUT
    } top_state_t;

    typedef enum logic [3:0] {
        N_IDLE,
        N_MUL_HI,
        N_MUL_LO,
        N_BASE,
        N_NORM,
        N_LOG_MUL,
        N_LOG,
        N_BETA_MUL,
        N_EXPY,
        N_EXP_MUL,
        N_GAIN_MUL,
        N_D_MUL,
        N_ROUND,
        N_DONE
    } norm_state_t;

    // Fractional log2 of m / 2^30 for m in [2^30, 2^31), Q0.30, truncated.
    function automatic logic [29:0] frac_log2_q30(input logic [63:0] m_in);
        logic [63:0] m;
        logic [29:0] r;
        m = m_in;
        r = '0;
        for (int b = 29; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= 64'd2147483648) begin
                m = m >> 1;
                r[b] = 1'b1;
            end
        end
        return r;
    endfunction

    // log2(1 + i/N) in Q0.24.
    function automatic tab_t make_log_tab();
        tab_t        tab;
        logic [63:0] t;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            t = (64'(i) << 30) / TABLE_ENTRIES;
            tab[i] = TAB_W'(({34'd0, frac_log2_q30((64'd1 << 30) + t)} + 64'd32) >> 6);
        end
        tab[TABLE_ENTRIES] = TAB_W'(64'd1 << 24);
        return tab;
    endfunction

    // 2^(i/N) in Q1.24, found by bisection on the log.
    function automatic tab_t make_exp_tab();
        tab_t        tab;
        logic [63:0] t;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            t  = (64'(i) << 30) / TABLE_ENTRIES;
            lo = 64'd1 << 30;
            hi = 64'd1 << 31;
            for (int s = 0; s < 30; s++) begin
                mid = lo + ((hi - lo) >> 1);
                if ({34'd0, frac_log2_q30(mid)} <= t) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
            tab[i] = TAB_W'((lo + 64'd32) >> 6);
        end
        tab[TABLE_ENTRIES] = TAB_W'(64'd1 << 25);
        return tab;
    endfunction

endpackage

`default_nettype wire

>>> src/lrn_mul.sv
`default_nettype none

module lrn_mul
    import lrn_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic [MUL_W-1:0]   op_a,
    input  wire logic [MUL_W-1:0]   op_b,
    output logic [2*MUL_W-1:0]      prod_reg
);

    logic [2*MUL_W-1:0] prod_next;

    // Shared unsigned multiplier with a registered product.
    assign prod_next = op_a * op_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

>>> src/lrn_norm.sv
`default_nettype none

module lrn_norm
    import lrn_pkg::*;
#(
    parameter int SUM_W = 36
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [SUM_W-1:0]      sum,
    input  wire logic signed [D_W-1:0] d,
    input  wire lrn_cfg_t              cfg,
    output logic                       done,
    output logic [15:0]                value
);

    localparam tab_t LOG_TAB   = make_log_tab();
    localparam tab_t EXP_TAB   = make_exp_tab();
    localparam int   LOG_REM_W = 30 - TAB_BITS;
    localparam int   EXP_REM_W = 24 - TAB_BITS;

    norm_state_t          state_reg, state_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [D_W-2:0]       dmag_reg;
    logic                 dneg_reg;
    logic                 zero_reg;
    logic [63:0]          base_reg;
    logic [5:0]           sc_reg;
    logic [2:0]           step_reg;
    logic signed [32:0]   lg_reg;
    logic signed [33:0]   y_reg;
    logic [15:0]          value_reg;

    logic [MUL_W-1:0]     op_a, op_b;
    logic [2*MUL_W-1:0]   prod_reg;

    lrn_mul u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    // Table lookups for the log and exp interpolation.
    logic [TAB_BITS-1:0]  log_idx, exp_idx;
    logic [TAB_W-1:0]     log_a, log_b, exp_a, exp_b, log_diff, exp_diff;
    logic [LOG_REM_W-1:0] log_rem;
    logic [EXP_REM_W-1:0] exp_rem;

    assign log_idx  = base_reg[62 -: TAB_BITS];
    assign log_rem  = base_reg[62-TAB_BITS:33];
    assign exp_idx  = y_reg[23 -: TAB_BITS];
    assign exp_rem  = y_reg[EXP_REM_W-1:0];
    assign log_a    = LOG_TAB[log_idx];
    assign log_b    = LOG_TAB[{1'b0, log_idx} + (TAB_BITS+1)'(1)];
    assign exp_a    = EXP_TAB[exp_idx];
    assign exp_b    = EXP_TAB[{1'b0, exp_idx} + (TAB_BITS+1)'(1)];
    assign log_diff = (log_b > log_a) ? log_b - log_a : '0;
    assign exp_diff = (exp_b > exp_a) ? exp_b - exp_a : '0;

    // Intermediate values formed from the registered product.
    logic [63:0]        base_sum;
    logic [6:0]         amt;
    logic [63:0]        amt_mask_test;
    logic [6:0]         pos;
    logic signed [32:0] lg_val;
    logic [31:0]        lg_mag;
    logic signed [48:0] t_signed;
    logic [TAB_W:0]     ev;
    logic [50:0]        m2;
    logic signed [9:0]  n_val;
    logic signed [11:0] s_val;
    logic [51:0]        rnd;
    logic [20:0]        mag;
    logic signed [22:0] v_mag, v_sum, v_lim;
    logic [15:0]        value_next;

    assign base_sum      = base_reg + (prod_reg[63:0] >> 16);
    assign amt           = 7'd32 >> step_reg;
    assign amt_mask_test = base_reg >> (7'd64 - amt);
    assign pos           = 7'd63 - {1'b0, sc_reg};
    assign lg_val        = ($signed({26'd0, pos}) - 33'sd16) * 33'sd16777216
                           + $signed({7'd0, log_a})
                           + $signed({7'd0, 26'(prod_reg >> LOG_REM_W)});
    assign lg_mag        = lg_reg[32] ? 32'(-lg_reg) : 32'(lg_reg);
    assign t_signed      = lg_reg[32] ? $signed({1'b0, prod_reg[47:0]})
                                      : -$signed({1'b0, prod_reg[47:0]});
    assign ev            = {1'b0, exp_a} + (TAB_W+1)'(prod_reg >> EXP_REM_W);
    assign m2            = prod_reg[50:0];
    assign n_val         = 10'(y_reg >>> 24);
    assign s_val         = 12'sd24 - 12'(n_val);
    assign rnd           = ({1'b0, m2} + (52'd1 << (s_val[5:0] - 6'd1))) >> s_val[5:0];

    // Rounding, saturation, zero point and clamping.
    always_comb begin
        if (zero_reg || m2 == '0 || s_val >= 12'sd51) begin
            mag = '0;
        end else if (s_val <= 12'sd0) begin
            mag = SAT_MAG;
        end else if (rnd > 52'(SAT_MAG)) begin
            mag = SAT_MAG;
        end else begin
            mag = rnd[20:0];
        end
        v_mag = dneg_reg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
        v_sum = v_mag + 23'(cfg.out_zp);
        v_lim = cfg.precision ? 23'sd32767 : 23'sd127;
        if (v_sum > v_lim) begin
            value_next = 16'(v_lim);
        end else if (v_sum < -v_lim - 23'sd1) begin
            value_next = 16'(-v_lim - 23'sd1);
        end else begin
            value_next = 16'(v_sum);
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE: begin
                if (start) begin
                    state_next = ((sum == '0 && cfg.k_bias == '0) || d == '0)
                                 ? N_ROUND : N_MUL_HI;
                end
            end
            N_MUL_HI:   state_next = N_MUL_LO;
            N_MUL_LO:   state_next = N_BASE;
            N_BASE:     state_next = N_NORM;
            N_NORM:     state_next = (step_reg == 3'd5) ? N_LOG_MUL : N_NORM;
            N_LOG_MUL:  state_next = N_LOG;
            N_LOG:      state_next = N_BETA_MUL;
            N_BETA_MUL: state_next = N_EXPY;
            N_EXPY:     state_next = N_EXP_MUL;
            N_EXP_MUL:  state_next = N_GAIN_MUL;
            N_GAIN_MUL: state_next = N_D_MUL;
            N_D_MUL:    state_next = N_ROUND;
            N_ROUND:    state_next = N_DONE;
            N_DONE:     state_next = N_IDLE;
            default:    state_next = N_IDLE;
        endcase
    end

    // Multiplier operands and status per state.
    always_comb begin
        op_a = '0;
        op_b = '0;
        done = 1'b0;
        unique case (state_reg)
            N_MUL_HI: begin
                op_a = MUL_W'(cfg.alpha);
                op_b = MUL_W'(sum_reg >> 16);
            end
            N_MUL_LO: begin
                op_a = MUL_W'(cfg.alpha);
                op_b = MUL_W'(sum_reg[15:0]);
            end
            N_LOG_MUL: begin
                op_a = MUL_W'(log_diff);
                op_b = MUL_W'(log_rem);
            end
            N_BETA_MUL: begin
                op_a = MUL_W'(cfg.beta);
                op_b = MUL_W'(lg_mag);
            end
            N_EXP_MUL: begin
                op_a = MUL_W'(exp_diff);
                op_b = MUL_W'(exp_rem);
            end
            N_GAIN_MUL: begin
                op_a = MUL_W'(ev);
                op_b = MUL_W'(cfg.gain);
            end
            N_D_MUL: begin
                op_a = prod_reg[57:24];
                op_b = MUL_W'(dmag_reg);
            end
            N_DONE:  done = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            N_IDLE: begin
                if (start) begin
                    sum_reg  <= sum;
                    dneg_reg <= d[D_W-1];
                    dmag_reg <= d[D_W-1] ? (D_W-1)'(-d) : (D_W-1)'(d);
                    zero_reg <= (sum == '0 && cfg.k_bias == '0) || d == '0;
                end
            end
            N_MUL_LO: begin
                base_reg <= {40'd0, cfg.k_bias} + prod_reg[63:0];
            end
            N_BASE: begin
                base_reg <= (base_sum == '0) ? 64'd1 : base_sum;
                sc_reg   <= '0;
                step_reg <= '0;
            end
            N_NORM: begin
                if (amt_mask_test == '0) begin
                    base_reg <= base_reg << amt;
                    sc_reg   <= sc_reg + amt[5:0];
                end
                step_reg <= step_reg + 3'd1;
            end
            N_LOG:   lg_reg    <= lg_val;
            N_EXPY:  y_reg     <= 34'(t_signed >>> 14);
            N_ROUND: value_reg <= value_next;
            default: ;
        endcase
    end

    assign value = value_reg;

    // A new request only arrives while the engine is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == N_IDLE)
        else $error("normalization started while busy");

    // The leading-one search leaves the top bit set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == N_NORM && step_reg == 3'd5) |=> base_reg[63])
        else $error("base not normalized after shift search");

    // The engine reports completion for one cycle and then frees itself.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == N_DONE) |=> state_reg == N_IDLE)
        else $error("engine did not return to idle after completion");

endmodule

`default_nettype wire

>>> src/cross_channel_lrn_quantized.sv
// Quantized local response normalization across channels.
//
// Input channel (s_valid/s_ready): one sample per transaction, channels of a
// pixel in order, s_last_channel set on the pixel's last channel.
// Output channel (m_valid/m_ready): one normalized sample per transaction;
// m_last_of_run marks the last result caused by an input transaction and
// m_end_of_pixel the result of the pixel's last channel.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr; the user
// must make writes only while the block is idle, which it does not enforce.
//
// The block handles one input transaction at a time; s_ready is high only
// while it waits for input. Each result sums up to 2h+1 squares of the window
// (one square per cycle) and then passes through the shared-multiplier
// sequencer and the control states; a zero sample or a zero sum with zero bias
// takes the short path of the sequencer, which skips its multiplier steps.
// An input that releases no result passes the check state and returns to idle.
// The result sits in an output register; the sequencer stalls only when a
// new result is ready and that register still holds an untaken one.
// Reset returns the configuration and control registers to their defaults and starts a new pixel.
`default_nettype none

module cross_channel_lrn_quantized
    import lrn_pkg::*;
#(
    parameter int MAX_LOCAL = 15
)
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic signed [15:0]     s_sample,
    input  wire logic                   s_last_channel,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [15:0]          m_value,
    output logic                        m_last_of_run,
    output logic                        m_end_of_pixel,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IW      = (MAX_LOCAL > 1) ? $clog2(MAX_LOCAL) : 1;
    localparam int SUM_W   = SQ_W + $clog2(MAX_LOCAL + 1);
    localparam int H_LIMIT = ((MAX_LOCAL - 1) / 2 < DELAY_DEPTH - 1)
                             ? (MAX_LOCAL - 1) / 2 : DELAY_DEPTH - 1;

    // Configuration registers.
    logic [3:0]         local_size_reg;
    logic [23:0]        k_bias_reg;
    logic [31:0]        alpha_reg;
    logic [15:0]        beta_reg;
    logic signed [15:0] in_zp_reg;
    logic signed [15:0] out_zp_reg;
    logic [31:0]        gain_reg;
    logic               precision_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_size_reg <= 4'd5;
            k_bias_reg     <= 24'd65536;
            alpha_reg      <= '0;
            beta_reg       <= 16'd12288;
            in_zp_reg      <= '0;
            out_zp_reg     <= '0;
            gain_reg       <= 32'd16777216;
            precision_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LOCAL_SIZE: local_size_reg <= cfg_wdata[3:0];
                REG_K_BIAS:     k_bias_reg     <= cfg_wdata[23:0];
                REG_ALPHA:      alpha_reg      <= cfg_wdata;
                REG_BETA:       beta_reg       <= cfg_wdata[15:0];
                REG_IN_ZP:      in_zp_reg      <= cfg_wdata[15:0];
                REG_OUT_ZP:     out_zp_reg     <= cfg_wdata[15:0];
                REG_GAIN:       gain_reg       <= cfg_wdata;
                REG_PRECISION:  precision_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    lrn_cfg_t cfg_bus;
    assign cfg_bus = '{k_bias: k_bias_reg, alpha: alpha_reg, beta: beta_reg,
                       out_zp: out_zp_reg, gain: gain_reg, precision: precision_reg};

    // Half width, limited by the window and the delay line.
    logic [2:0] h;
    assign h = (local_size_reg[3:1] > 3'(H_LIMIT)) ? 3'(H_LIMIT) : local_size_reg[3:1];

    // Zero-point corrected sample and its square.
    logic signed [15:0]    x_in;
    logic signed [D_W-1:0] d_in;
    logic signed [33:0]    sq_full;
    assign x_in    = precision_reg ? s_sample : 16'(s_sample[7:0]) ^ 16'(s_sample[7] ? 16'hFF00 : 16'h0);
    assign d_in    = D_W'(x_in) - D_W'(in_zp_reg);
    assign sq_full = d_in * d_in;

    top_state_t            state_reg, state_next;
    logic [SQ_W-1:0]       win_reg [MAX_LOCAL];
    logic signed [D_W-1:0] delay_reg [DELAY_DEPTH];
    logic [15:0]           cc_reg, emitted_reg;
    logic [RUN_W-1:0]      run_reg;
    logic                  last_reg;
    logic [IW-1:0]         ptr_reg, hi_reg;
    logic [2:0]            r_reg;
    logic                  empty_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic                  m_valid_reg;
    logic signed [15:0]    m_value_reg;
    logic                  m_last_reg, m_eop_reg;

    logic                  norm_start, norm_done;
    logic [15:0]           norm_value;

    // Emission bookkeeping for the channel emitted next.
    logic [15:0] j;
    logic [15:0] lag;
    logic [2:0]  r_now;
    logic [16:0] lo_now;
    logic [15:0] hi_now;
    logic [16:0] c1;
    logic        more_now, more_next, out_free;

    assign j        = cc_reg - 16'd1;
    assign lag      = j - emitted_reg;
    assign r_now    = (lag > 16'(DELAY_DEPTH - 1)) ? 3'(DELAY_DEPTH - 1) : lag[2:0];
    assign more_now = (run_reg < RUN_W'(MAX_RUN)) && (emitted_reg < cc_reg)
                      && (last_reg || ({1'b0, emitted_reg} + 17'(h) <= {1'b0, j}));
    assign c1        = {1'b0, emitted_reg} + 17'd1;
    assign more_next = (run_reg + RUN_W'(1) < RUN_W'(MAX_RUN)) && (c1 < {1'b0, cc_reg})
                       && (last_reg || (c1 + 17'(h) <= {1'b0, j}));
    assign lo_now    = ({1'b0, emitted_reg} + 17'(h) >= {1'b0, j})
                       ? 17'd0 : {1'b0, j} - {1'b0, emitted_reg} - 17'(h);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        hi_now = 16'(r_now) + 16'(h);
        if (hi_now > j) begin
            hi_now = j;
        end
        if (hi_now > 16'(MAX_LOCAL - 1)) begin
            hi_now = 16'(MAX_LOCAL - 1);
        end
    end

    // Next-state logic of the control sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:  if (s_valid) state_next = T_CHECK;
            T_CHECK: state_next = more_now ? T_SUM : T_IDLE;
            T_SUM:   if (empty_reg || ptr_reg == hi_reg) state_next = T_START;
            T_START: state_next = T_WAIT;
            T_WAIT:  if (norm_done) state_next = T_OUT;
            T_OUT:   if (out_free) state_next = T_CHECK;
            default: state_next = T_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready    = 1'b0;
        norm_start = 1'b0;
        unique case (state_reg)
            T_IDLE:  s_ready = 1'b1;
            T_START: norm_start = 1'b1;
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            cc_reg      <= '0;
            emitted_reg <= '0;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == T_IDLE && s_valid) begin
                if (cc_reg != 16'hFFFF) begin
                    cc_reg <= cc_reg + 16'd1;
                end
                run_reg <= '0;
            end
            if (state_reg == T_CHECK && !more_now && last_reg) begin
                cc_reg      <= '0;
                emitted_reg <= '0;
            end
            if (state_reg == T_OUT && out_free) begin
                emitted_reg <= emitted_reg + 16'd1;
                run_reg     <= run_reg + RUN_W'(1);
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Window, delay line, summation and output payload.
    always_ff @(posedge aclk) begin
        if (state_reg == T_IDLE && s_valid) begin
            win_reg[0] <= sq_full[SQ_W-1:0];
            for (int p = 1; p < MAX_LOCAL; p++) begin
                win_reg[p] <= win_reg[p-1];
            end
            delay_reg[0] <= d_in;
            for (int p = 1; p < DELAY_DEPTH; p++) begin
                delay_reg[p] <= delay_reg[p-1];
            end
            last_reg <= s_last_channel;
        end
        if (state_reg == T_CHECK) begin
            r_reg     <= r_now;
            ptr_reg   <= IW'(lo_now);
            hi_reg    <= IW'(hi_now);
            empty_reg <= lo_now > {1'b0, hi_now};
            acc_reg   <= '0;
        end
        if (state_reg == T_SUM) begin
            if (!empty_reg) begin
                acc_reg <= acc_reg + SUM_W'(win_reg[ptr_reg]);
            end
            ptr_reg <= ptr_reg + IW'(1);
        end
        if (state_reg == T_OUT && out_free) begin
            m_value_reg <= norm_value;
            m_last_reg  <= !more_next;
            m_eop_reg   <= last_reg && (emitted_reg == j);
        end
    end

    lrn_norm #(
        .SUM_W (SUM_W)
    ) u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .sum     (acc_reg),
        .d       (delay_reg[r_reg]),
        .cfg     (cfg_bus),
        .done    (norm_done),
        .value   (norm_value)
    );

    assign m_valid        = m_valid_reg;
    assign m_value        = m_value_reg;
    assign m_last_of_run  = m_last_reg;
    assign m_end_of_pixel = m_eop_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        emitted_reg <= cc_reg)
        else $error("more channels emitted than received");

    assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= RUN_W'(MAX_RUN))
        else $error("too many results for one input");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_pixel) |-> m_last_of_run)
        else $error("pixel end not on the last result of its run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_IDLE && $past(state_reg) == T_CHECK && last_reg) |-> cc_reg == '0)
        else $error("channel count not cleared at pixel end");

endmodule

`default_nettype wire
